### src/earcon_grain_voice_synth_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the earcon grain voice synthesizer checker
// Each macro expects signals named clock and reset in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef EARCON_GRAIN_VOICE_SYNTH_TOP_ASSERT_SVH
`define EARCON_GRAIN_VOICE_SYNTH_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EGVS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EGVS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/egvs_pkg.sv
// ----------------------------------------------------------------------------
// egvs_pkg
// Types, constants, gesture tables and table generators for the synthesizer.
// ----------------------------------------------------------------------------
package egvs_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 18;
   localparam int SR_W        = 18;
   localparam int VOL_W       = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VOLUME      = 1'b1;

   localparam logic [SR_W-1:0]  SAMPLE_RATE_RESET = 18'd48000;
   localparam logic [VOL_W-1:0] VOLUME_RESET      = 16'd39322;

   localparam logic OP_TRIGGER = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam int GESTURES = 11;
   localparam int GRAINS   = 21;

   // Divider geometry: widest numerator is position * 1000 * 2^16 for the attack.
   localparam int DIV_NUM_W = 44;
   localparam int DIV_DEN_W = 18;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   localparam logic [DIV_NUM_W-1:0] ROUND_UP_MS   = 44'd999;
   localparam logic [DIV_NUM_W-1:0] RECIP_NUMER   = 44'h000_00FF_FFFF;

   // Division by 1000 as a shift by three and a multiply by ceil(2^30 / 125).
   // Exact for every shifted numerator below 2^23.
   localparam int          MS_PRE_SHIFT   = 3;
   localparam int          MS_RECIP_SHIFT = 30;
   localparam logic [23:0] MS_RECIP       = 24'd8589935;

   localparam logic [16:0] ENV_UNITY       = 17'h10000;
   localparam logic [16:0] SHORT_DECAY_ONE = 17'd24109;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic [10:0] GRAIN_FREQ [GRAINS] = '{
      11'd587, 11'd880, 11'd880, 11'd587, 11'd1175, 11'd1175, 11'd1175,
      11'd784, 11'd523, 11'd659, 11'd659, 11'd698, 11'd1047, 11'd1047,
      11'd698, 11'd350, 11'd350, 11'd988, 11'd196, 11'd196, 11'd196};
   localparam logic [7:0] GRAIN_START [GRAINS] = '{
      8'd0, 8'd50, 8'd0, 8'd50, 8'd0, 8'd70, 8'd140, 8'd0, 8'd0, 8'd0, 8'd45,
      8'd0, 8'd50, 8'd0, 8'd50, 8'd0, 8'd70, 8'd0, 8'd0, 8'd110, 8'd220};
   localparam logic [7:0] GRAIN_DUR [GRAINS] = '{
      8'd55, 8'd65, 8'd55, 8'd70, 8'd45, 8'd45, 8'd55, 8'd60, 8'd70, 8'd35,
      8'd35, 8'd55, 8'd65, 8'd55, 8'd70, 8'd60, 8'd60, 8'd40, 8'd90, 8'd90,
      8'd90};
   localparam logic [4:0] GEST_FIRST [GESTURES] = '{
      5'd0, 5'd2, 5'd4, 5'd7, 5'd8, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17, 5'd18};
   localparam logic [1:0] GEST_COUNT [GESTURES] = '{
      2'd2, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd3};

   typedef struct packed {
      logic       opcode;
      logic [3:0] gesture;
      logic [1:0] pan;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic               saturated;
   } rsp_payload_type;

   // One voice as it sits in the state memory.
   typedef struct packed {
      logic [1:0]         side;
      logic [31:0]        phase;
      logic [31:0]        step;
      logic signed [17:0] position;
      logic [15:0]        length;
      logic [23:0]        recip;
   } voice_rec_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numerator;
      logic [DIV_DEN_W-1:0] denominator;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   // sin(t * pi / 2) for t in Q16 over [0, 65536], as Q15.
   function automatic logic [15:0] quarter_sine(input logic [63:0] t16);
      logic [63:0] x, x2, h, s, q;
      x  = (t16 * HALF_PI_Q30) >> 16;
      x2 = (x * x) >> 30;
      h  = Q30_ONE - x2 / 72;
      h  = Q30_ONE - ((x2 * h) >> 30) / 42;
      h  = Q30_ONE - ((x2 * h) >> 30) / 20;
      h  = Q30_ONE - ((x2 * h) >> 30) / 6;
      s  = (x * h) >> 30;
      q  = (s + (64'd1 << 14)) >> 15;
      return (q > 64'd32767) ? 16'd32767 : q[15:0];
   endfunction

   function automatic logic signed [15:0] sine_entry(input int unsigned idx,
                                                     input int unsigned bits);
      int unsigned qbits, quad;
      logic [63:0] t16;
      logic [15:0] v;
      qbits = bits - 2;
      quad  = idx >> qbits;
      t16   = 64'((idx & ((32'd1 << qbits) - 32'd1)) << (16 - qbits));
      v     = quad[0] ? quarter_sine(64'd65536 - t16) : quarter_sine(t16);
      return quad[1] ? -$signed(v) : $signed(v);
   endfunction

   // exp(-y) for y in Q30, y small.
   function automatic logic [63:0] exp_small(input logic [63:0] y);
      logic [63:0] h;
      h = Q30_ONE - y / 6;
      h = Q30_ONE - ((y * h) >> 30) / 5;
      h = Q30_ONE - ((y * h) >> 30) / 4;
      h = Q30_ONE - ((y * h) >> 30) / 3;
      h = Q30_ONE - ((y * h) >> 30) / 2;
      return Q30_ONE - ((y * h) >> 30);
   endfunction

   // Decay entry in Q16: exp(-y) raised to the eighth power.
   function automatic logic [16:0] decay_entry(input logic [63:0] y);
      logic [63:0] e, r;
      e = exp_small(y);
      for (int j = 0; j < 3; j++) begin
         e = (e * e + (64'd1 << 29)) >> 30;
      end
      r = (e + (64'd1 << 13)) >> 14;
      return r[16:0];
   endfunction

endpackage

### src/egvs_stream_if.sv
// ----------------------------------------------------------------------------
// egvs_stream_if
// Valid/ready channel carrying one payload word per accepted request.
// ----------------------------------------------------------------------------
interface egvs_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/egvs_ram.sv
// ----------------------------------------------------------------------------
// egvs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module egvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### src/egvs_divider.sv
// ----------------------------------------------------------------------------
// egvs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module egvs_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  egvs_pkg::div_req_type req,
   output egvs_pkg::div_rsp_type rsp
);
   localparam int NW = egvs_pkg::DIV_NUM_W;
   localparam int DW = egvs_pkg::DIV_DEN_W;
   localparam int CW = egvs_pkg::DIV_CNT_W;

   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] count_ff, count_in;
   logic          done_ff, done_in;
   logic [DW:0]   rem_shift;
   logic [DW:0]   rem_sub;
   logic          fits;

   assign rem_shift = {rem_ff, quo_ff[NW-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign rem_sub   = rem_shift - {1'b0, den_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (req.start) begin
         rem_in   = '0;
         quo_in   = req.numerator;
         den_in   = req.denominator;
         count_in = CW'(NW);
      end else if (count_ff != '0) begin
         rem_in   = fits ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
         quo_in   = {quo_ff[NW-2:0], fits};
         count_in = count_ff - CW'(1);
         done_in  = (count_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

### src/egvs_tables.sv
// ----------------------------------------------------------------------------
// egvs_tables
// Sine and decay lookup tables built at elaboration, with registered reads.
// ----------------------------------------------------------------------------
module egvs_tables #(
   parameter int SINE_TABLE_BITS  = 10,
   parameter int DECAY_TABLE_BITS = 8
) (
   input  logic                        clock,
   input  logic [SINE_TABLE_BITS-1:0]  sine_addr,
   input  logic [DECAY_TABLE_BITS-1:0] decay_addr,
   output logic signed [15:0]          sine_data,
   output logic [16:0]                 decay_data
);
   localparam int SineDepth  = 1 << SINE_TABLE_BITS;
   localparam int DecayDepth = 1 << DECAY_TABLE_BITS;
   // Decay index k maps to exp(-k / (0.35 * depth)), reached as an eighth power by squaring.
   localparam logic [63:0] DecayDen = 64'd56 << DECAY_TABLE_BITS;

   logic signed [15:0] sine_rom [SineDepth];
   logic [16:0]        decay_rom [DecayDepth];
   logic signed [15:0] sine_data_ff;
   logic [16:0]        decay_data_ff;

   for (genvar i = 0; i < SineDepth; i++) begin : g_sine
      assign sine_rom[i] = egvs_pkg::sine_entry(i, SINE_TABLE_BITS);
   end

   for (genvar k = 0; k < DecayDepth; k++) begin : g_decay
      localparam logic [63:0] Y = ((64'(k) * 64'd20 << 30) + DecayDen / 2) / DecayDen;
      assign decay_rom[k] = egvs_pkg::decay_entry(Y);
   end

   always_ff @(posedge clock) begin
      sine_data_ff  <= sine_rom[sine_addr];
      decay_data_ff <= decay_rom[decay_addr];
   end

   assign sine_data  = sine_data_ff;
   assign decay_data = decay_data_ff;
endmodule

### src/earcon_grain_voice_synth_top.sv
// ----------------------------------------------------------------------------
// earcon_grain_voice_synth_top
// Trigger: accept, then per grain search the busy flags for a free voice, compute
//    length and delay (multiply by 1/1000, numerator then product), phase step and
//    length reciprocal on the shared one-bit-per-cycle divider, and claim.
// Tick: pass over idle voices; a voice in its start delay runs READ, LOAD, UPD; a
//    sounding voice READ, LOAD, MUL, ATK, ENV, VOL, MAG, UPD, with ATK held on the
//    divider in its attack; OUT presents the frame once the previous one is taken.
// One request is worked at a time; a finished frame waits in the output register.
// Reset is synchronous; busy flags clear at once, no memory clearing pass.
// ----------------------------------------------------------------------------
module earcon_grain_voice_synth_top #(
   parameter int VOICES           = 16,
   parameter int SINE_TABLE_BITS  = 10,
   parameter int DECAY_TABLE_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   egvs_stream_if.sink                        req_chan,
   egvs_stream_if.source                      rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [egvs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [egvs_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   // Voice index width, and an accumulator wide enough for every voice at
   // full scale on one side.
   localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int ACC_W = 17 + VW;
   localparam int REC_W = $bits(egvs_pkg::voice_rec_type);

   // The sequencer. Trigger requests walk the busy flags for a free voice and
   // then compute the grain's length and delay by a reciprocal multiply, and
   // its phase step and length reciprocal on the divider, before writing the
   // voice record. Tick requests read each busy voice, build the envelope and sine
   // product of a sounding one in a short chain of registered steps, and write the
   // advanced voice back.
   typedef enum logic [15:0] {
      S_IDLE   = 16'h0001,
      S_FIND   = 16'h0002,
      S_DLEN   = 16'h0004,
      S_DDLY   = 16'h0008,
      S_DSTEP  = 16'h0010,
      S_DRECIP = 16'h0020,
      S_CLAIM  = 16'h0040,
      S_READ   = 16'h0080,
      S_LOAD   = 16'h0100,
      S_MUL    = 16'h0200,
      S_ATK    = 16'h0400,
      S_ENV    = 16'h0800,
      S_VOL    = 16'h1000,
      S_MAG    = 16'h2000,
      S_UPD    = 16'h4000,
      S_OUT    = 16'h8000
   } state_type;

   state_type                     state_ff, state_in;
   logic [VW-1:0]                 vidx_ff, vidx_in;
   logic [VOICES-1:0]             busy_ff, busy_in;
   logic [egvs_pkg::SR_W-1:0]     sr_ff, sr_in;
   logic [egvs_pkg::VOL_W-1:0]    vol_ff, vol_in;
   logic [4:0]                    grain_ff, grain_in;
   logic [1:0]                    grains_left_ff, grains_left_in;
   logic [1:0]                    pan_ff, pan_in;
   logic [15:0]                   len_ff, len_in;
   logic [15:0]                   delay_ff, delay_in;
   logic [31:0]                   step_ff, step_in;
   logic [22:0]                   ms_num_ff, ms_num_in;
   logic                          div_wait_ff, div_wait_in;
   egvs_pkg::voice_rec_type       rec_ff, rec_in;
   logic [16:0]                   attack_ff, attack_in;
   logic [23:0]                   prod_ff, prod_in;
   logic [16:0]                   env_ff, env_in;
   logic [32:0]                   gain_ff, gain_in;
   logic                          sine_neg_ff, sine_neg_in;
   logic [14:0]                   sine_mag_ff, sine_mag_in;
   logic signed [ACC_W-1:0]       acc_left_ff, acc_left_in;
   logic signed [ACC_W-1:0]       acc_right_ff, acc_right_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   egvs_pkg::rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   egvs_pkg::req_payload_type     req_payload;
   egvs_pkg::div_req_type         div_req;
   egvs_pkg::div_rsp_type         div_rsp;
   logic                          ram_wr_en;
   logic                          ram_rd_en;
   logic [REC_W-1:0]              ram_wr_data;
   logic [REC_W-1:0]              ram_rd_data;
   egvs_pkg::voice_rec_type       rec_rd;
   egvs_pkg::voice_rec_type       rec_new;
   logic signed [15:0]            sine_data;
   logic [16:0]                   decay_data;

   logic                          last_voice;
   logic                          req_fire;
   logic [25:0]                   dur_sr;
   logic [25:0]                   start_sr;
   logic [46:0]                   ms_quot;
   logic [17:0]                   pos_u;
   logic [27:0]                   pos_k;
   logic                          attack_full;
   logic [41:0]                   pos_recip;
   logic signed [18:0]            pos_next;
   logic                          voice_done;
   logic [16:0]                   decay_sel;
   logic [33:0]                   env_prod;
   logic [32:0]                   gain_prod;
   logic [47:0]                   mag_prod;
   logic [15:0]                   mag;
   logic signed [ACC_W-1:0]       contrib;
   logic                          to_left;
   logic                          to_right;
   logic                          left_hi, left_lo, right_hi, right_lo;
   logic signed [15:0]            left_clamped, right_clamped;

   assign req_payload = req_chan.payload;
   assign req_fire    = req_chan.valid && (state_ff == S_IDLE);
   assign last_voice  = (vidx_ff == VW'(VOICES - 1));
   assign rec_rd      = egvs_pkg::voice_rec_type'(ram_rd_data);

   // Spawn arithmetic operands. The rounded-up millisecond product, already
   // divided by eight, is registered before the multiply by 1/125.
   assign dur_sr   = 26'(egvs_pkg::GRAIN_DUR[grain_ff]) * 26'(sr_ff);
   assign start_sr = 26'(egvs_pkg::GRAIN_START[grain_ff]) * 26'(sr_ff);
   assign ms_quot  = 47'(ms_num_ff) * 47'(egvs_pkg::MS_RECIP);

   // Render arithmetic. Position is non-negative whenever these are used.
   assign pos_u       = 18'(rec_ff.position);
   assign pos_k       = 28'(pos_u) * 28'd1000;
   assign attack_full = pos_k >= 28'(sr_ff);
   assign pos_recip   = 42'(pos_u) * 42'(rec_ff.recip);
   assign pos_next    = {rec_ff.position[17], rec_ff.position} + 19'sd1;
   assign voice_done  = pos_next >= $signed({3'b000, rec_ff.length});

   // Grains shorter than three frames use tau of one frame directly.
   assign decay_sel = (rec_ff.length >= 16'd3) ? decay_data
                    : ((pos_u == '0) ? egvs_pkg::ENV_UNITY : egvs_pkg::SHORT_DECAY_ONE);
   assign env_prod  = 34'(attack_ff) * 34'(decay_sel);
   assign gain_prod = 33'(vol_ff) * 33'(env_ff);
   assign mag_prod  = 48'(gain_ff) * 48'(sine_mag_ff);
   assign mag       = mag_prod[47:32];
   assign contrib   = sine_neg_ff ? -$signed(ACC_W'(mag)) : $signed(ACC_W'(mag));
   assign to_left   = (rec_ff.side == 2'd0) || (rec_ff.side == 2'd2);
   assign to_right  = (rec_ff.side == 2'd1) || (rec_ff.side == 2'd2);

   // Output saturation of the channel sums.
   assign left_hi  = acc_left_ff > $signed(ACC_W'(32767));
   assign left_lo  = acc_left_ff < -$signed(ACC_W'(32768));
   assign right_hi = acc_right_ff > $signed(ACC_W'(32767));
   assign right_lo = acc_right_ff < -$signed(ACC_W'(32768));
   assign left_clamped  = left_hi ? 16'sh7FFF : (left_lo ? 16'sh8000 : 16'(acc_left_ff));
   assign right_clamped = right_hi ? 16'sh7FFF : (right_lo ? 16'sh8000 : 16'(acc_right_ff));

   // A fresh voice: silent until its start delay has counted up to zero.
   always_comb begin
      rec_new          = '0;
      rec_new.side     = pan_ff;
      rec_new.step     = step_ff;
      rec_new.position = -$signed({2'b00, delay_ff});
      rec_new.length   = len_ff;
      rec_new.recip    = prod_ff;
   end

   always_comb begin
      state_in       = state_ff;
      vidx_in        = vidx_ff;
      busy_in        = busy_ff;
      sr_in          = sr_ff;
      vol_in         = vol_ff;
      grain_in       = grain_ff;
      grains_left_in = grains_left_ff;
      pan_in         = pan_ff;
      len_in         = len_ff;
      delay_in       = delay_ff;
      step_in        = step_ff;
      ms_num_in      = ms_num_ff;
      div_wait_in    = div_wait_ff;
      rec_in         = rec_ff;
      attack_in      = attack_ff;
      prod_in        = prod_ff;
      env_in         = env_ff;
      gain_in        = gain_ff;
      sine_neg_in    = sine_neg_ff;
      sine_mag_in    = sine_mag_ff;
      acc_left_in    = acc_left_ff;
      acc_right_in   = acc_right_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      div_req             = '0;
      div_req.denominator = sr_ff;
      div_req.numerator   = {pos_k, 16'h0000};
      ram_wr_en           = 1'b0;
      ram_wr_data         = rec_new;
      ram_rd_en           = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
      if (csr_write_enable) begin
         unique case (csr_index)
            egvs_pkg::CSR_SAMPLE_RATE: sr_in = csr_write_data[egvs_pkg::SR_W-1:0];
            egvs_pkg::CSR_VOLUME:      vol_in = csr_write_data[egvs_pkg::VOL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               vidx_in      = '0;
               pan_in       = req_payload.pan;
               acc_left_in  = '0;
               acc_right_in = '0;
               if (req_payload.opcode == egvs_pkg::OP_TICK) begin
                  if (sr_ff == '0) begin
                     // Playback disabled: drop every voice, emit silence.
                     busy_in  = '0;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_READ;
                  end
               end else if ((sr_ff != '0) &&
                            (req_payload.gesture < 4'(egvs_pkg::GESTURES))) begin
                  grain_in       = egvs_pkg::GEST_FIRST[req_payload.gesture];
                  grains_left_in = egvs_pkg::GEST_COUNT[req_payload.gesture];
                  state_in       = S_FIND;
               end
            end
         end
         S_FIND: begin
            if (!busy_ff[vidx_ff]) begin
               state_in = S_DLEN;
            end else if (last_voice) begin
               // Pool exhausted: the rest of the gesture is dropped.
               state_in = S_IDLE;
            end else begin
               vidx_in = vidx_ff + VW'(1);
            end
         end
         S_DLEN: begin
            // Length in frames, rounded up: the numerator is registered first, then
            // the reciprocal product is taken.
            if (!div_wait_ff) begin
               ms_num_in   = 23'((44'(dur_sr) + egvs_pkg::ROUND_UP_MS)
                                 >> egvs_pkg::MS_PRE_SHIFT);
               div_wait_in = 1'b1;
            end else begin
               len_in      = ms_quot[egvs_pkg::MS_RECIP_SHIFT +: 16];
               div_wait_in = 1'b0;
               state_in    = S_DDLY;
            end
         end
         S_DDLY: begin
            if (!div_wait_ff) begin
               ms_num_in   = 23'((44'(start_sr) + egvs_pkg::ROUND_UP_MS)
                                 >> egvs_pkg::MS_PRE_SHIFT);
               div_wait_in = 1'b1;
            end else begin
               delay_in    = ms_quot[egvs_pkg::MS_RECIP_SHIFT +: 16];
               div_wait_in = 1'b0;
               state_in    = S_DSTEP;
            end
         end
         S_DSTEP: begin
            // Rounded phase step; only the low 32 quotient bits are kept.
            div_req.numerator = {egvs_pkg::GRAIN_FREQ[grain_ff], 32'h0000_0000}
                              + 44'(sr_ff >> 1);
            if (!div_wait_ff) begin
               div_req.start = 1'b1;
               div_wait_in   = 1'b1;
            end else if (div_rsp.done) begin
               step_in     = div_rsp.quotient[31:0];
               div_wait_in = 1'b0;
               state_in    = S_DRECIP;
            end
         end
         S_DRECIP: begin
            div_req.numerator   = egvs_pkg::RECIP_NUMER;
            div_req.denominator = 18'(len_ff);
            if (!div_wait_ff) begin
               div_req.start = 1'b1;
               div_wait_in   = 1'b1;
            end else if (div_rsp.done) begin
               prod_in     = div_rsp.quotient[23:0];
               div_wait_in = 1'b0;
               state_in    = S_CLAIM;
            end
         end
         S_CLAIM: begin
            ram_wr_en         = 1'b1;
            busy_in[vidx_ff]  = 1'b1;
            grain_in          = grain_ff + 5'd1;
            grains_left_in    = grains_left_ff - 2'd1;
            state_in          = (grains_left_ff == 2'd1) ? S_IDLE : S_FIND;
         end
         S_READ: begin
            if (busy_ff[vidx_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = S_LOAD;
            end else if (last_voice) begin
               state_in = S_OUT;
            end else begin
               vidx_in = vidx_ff + VW'(1);
            end
         end
         S_LOAD: begin
            rec_in   = rec_rd;
            // A voice still in its start delay only counts its position up.
            state_in = rec_rd.position[17] ? S_UPD : S_MUL;
         end
         S_MUL: begin
            prod_in = pos_recip[23:0];
            if (attack_full) begin
               attack_in = egvs_pkg::ENV_UNITY;
            end else begin
               div_req.start = 1'b1;
               div_wait_in   = 1'b1;
            end
            state_in = S_ATK;
         end
         S_ATK: begin
            // Also lets the registered table reads land before S_ENV uses them.
            if (!div_wait_ff) begin
               state_in = S_ENV;
            end else if (div_rsp.done) begin
               attack_in   = div_rsp.quotient[16:0];
               div_wait_in = 1'b0;
               state_in    = S_ENV;
            end
         end
         S_ENV: begin
            env_in      = env_prod[32:16];
            sine_neg_in = sine_data[15];
            sine_mag_in = sine_data[15] ? 15'(-sine_data) : sine_data[14:0];
            state_in    = S_VOL;
         end
         S_VOL: begin
            gain_in  = gain_prod;
            state_in = S_MAG;
         end
         S_MAG: begin
            if (to_left) begin
               acc_left_in = acc_left_ff + contrib;
            end
            if (to_right) begin
               acc_right_in = acc_right_ff + contrib;
            end
            rec_in.phase = rec_ff.phase + rec_ff.step;
            state_in     = S_UPD;
         end
         S_UPD: begin
            ram_wr_en            = 1'b1;
            ram_wr_data          = rec_ff;
            ram_wr_data[REC_W-67 -: 18] = pos_next[17:0];
            if (voice_done) begin
               busy_in[vidx_ff] = 1'b0;
            end
            if (last_voice) begin
               state_in = S_OUT;
            end else begin
               vidx_in  = vidx_ff + VW'(1);
               state_in = S_READ;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.left_sample  = left_clamped;
               rsp_payload_in.right_sample = right_clamped;
               rsp_payload_in.saturated    = left_hi || left_lo || right_hi || right_lo;
               state_in                    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      vidx_ff        <= vidx_in;
      grain_ff       <= grain_in;
      grains_left_ff <= grains_left_in;
      pan_ff         <= pan_in;
      len_ff         <= len_in;
      delay_ff       <= delay_in;
      step_ff        <= step_in;
      ms_num_ff      <= ms_num_in;
      rec_ff         <= rec_in;
      attack_ff      <= attack_in;
      prod_ff        <= prod_in;
      env_ff         <= env_in;
      gain_ff        <= gain_in;
      sine_neg_ff    <= sine_neg_in;
      sine_mag_ff    <= sine_mag_in;
      acc_left_ff    <= acc_left_in;
      acc_right_ff   <= acc_right_in;
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         sr_ff        <= egvs_pkg::SAMPLE_RATE_RESET;
         vol_ff       <= egvs_pkg::VOLUME_RESET;
         div_wait_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         sr_ff        <= sr_in;
         vol_ff       <= vol_in;
         div_wait_ff  <= div_wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Voice records: side, phase, step, position, length and reciprocal.
   egvs_ram #(
      .WIDTH (REC_W),
      .DEPTH (VOICES)
   ) u_voice_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (vidx_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (vidx_ff),
      .rd_data (ram_rd_data)
   );

   egvs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   egvs_tables #(
      .SINE_TABLE_BITS  (SINE_TABLE_BITS),
      .DECAY_TABLE_BITS (DECAY_TABLE_BITS)
   ) u_tables (
      .clock      (clock),
      .sine_addr  (rec_ff.phase[31 -: SINE_TABLE_BITS]),
      .decay_addr (prod_ff[23 -: DECAY_TABLE_BITS]),
      .sine_data  (sine_data),
      .decay_data (decay_data)
   );

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;
endmodule

### src/egvs_checker.sv
// ----------------------------------------------------------------------------
// egvs_checker
// Port-level checks on the synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "earcon_grain_voice_synth_top_assert.svh"

module egvs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_opcode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_left,
   input logic [15:0] rsp_right,
   input logic        rsp_sat
);
   `EGVS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_left) && $stable(rsp_right) && $stable(rsp_sat), "response changed while stalled")
   `EGVS_ASSERT_NEXT(a_trigger_silent, req_valid && req_ready && !req_opcode, !$rose(rsp_valid), "trigger produced a response")
   `EGVS_ASSERT_NEXT(a_tick_busy, req_valid && req_ready && req_opcode, !req_ready, "ready stayed high after a tick")
   `EGVS_ASSERT_SAME(a_sat_clamped, rsp_valid && rsp_sat, rsp_left == 16'h7FFF || rsp_left == 16'h8000 || rsp_right == 16'h7FFF || rsp_right == 16'h8000, "saturated without a clamped sample")
endmodule

bind earcon_grain_voice_synth_top egvs_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_opcode (req_chan.payload.opcode),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_left   (rsp_chan.payload.left_sample),
   .rsp_right  (rsp_chan.payload.right_sample),
   .rsp_sat    (rsp_chan.payload.saturated)
);
